// ===== hdl/mt_pkg.sv =====
// Package for the MT19937 generator: widths, generator constants and the
// output tempering function. No dependencies.

package mt_pkg;

  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 7;
  localparam int DEPTH_DEF  = 624;
  localparam int SHIFT_DIST = 397;
  localparam int MAX_WORDS  = 64;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam word_t SEED_DEFAULT = 32'd5489;
  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam word_t TWIST_MAT    = 32'd2567483615;
  localparam word_t TEMPER_B     = 32'd2636928640;
  localparam word_t TEMPER_C     = 32'd4022730752;
  localparam word_t UPPER_MASK   = 32'h8000_0000;
  localparam word_t LOWER_MASK   = 32'h7fff_ffff;

  function automatic word_t temper(input word_t raw);
    word_t y;
    y = raw;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hdl/mt_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read.
// Self-contained, no package dependency.

module mt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_a_addr,
  output logic [WIDTH-1:0] rd_a_data,
  input  logic [AW-1:0]    rd_b_addr,
  output logic [WIDTH-1:0] rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== hdl/mersenne_twister_generator.sv =====
// MT19937 generator top level: sequencer, seeding multiplier, twist datapath
// and output buffering. Depends on mt_pkg and mt_ram.

// Standard 32-bit Mersenne Twister. Each input beat carries a word count
// (0 is dropped with no effect, anything above 64 saturates to 64) and the
// block returns that many tempered 32-bit words, flagging the final one with
// out_last_word. Words stream at one per cycle through table read port A
// while the output is not stalled and no twist is due. The state table sits
// in a 624-entry RAM. The first request after reset or after a seed write
// first seeds the table, one entry per cycle through the 32x32 seeding
// multiplier. Every 624 words, before the word at index zero, the table is
// twisted in place, one entry per cycle using both read ports. No new
// request is taken while a request is being worked on; the output register
// and a one-word holding stage catch a table read still in flight when the
// receiver stalls. Write the seed only while the block is idle and all
// words have been taken; cfg_ready is always high.

module mersenne_twister_generator #(
  parameter int TABLE_DEPTH = mt_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mt_pkg::COUNT_W-1:0]   in_word_count,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mt_pkg::WORD_W-1:0]    out_random_word,
  output logic                         out_last_word,
  // seed register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mt_pkg::WORD_W-1:0]    cfg_seed_value
);

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int CW      = $clog2(TABLE_DEPTH + 1);
  localparam int FAR_LIM = TABLE_DEPTH - mt_pkg::SHIFT_DIST;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_TWPRE = 3'd2;
  localparam logic [2:0] ST_TWIST = 3'd3;
  localparam logic [2:0] ST_GEN   = 3'd4;

  // control state
  logic [2:0]           state_r, state_nxt;
  mt_pkg::word_t        seed_r, seed_nxt;
  logic                 ready_r, ready_nxt;       // table seeded
  logic                 need_tw_r, need_tw_nxt;   // twist due before next read
  logic [AW-1:0]        idx_r, idx_nxt;
  mt_pkg::count_t       rem_r, rem_nxt;
  logic [AW-1:0]        fcnt_r, fcnt_nxt;
  logic [CW-1:0]        tw_cnt_r, tw_cnt_nxt;
  logic                 tw_v_r, tw_v_nxt;
  logic [AW-1:0]        tw_wa_r, tw_wa_nxt;
  logic                 rd_pend_r, rd_pend_nxt;
  logic                 rd_last_r, rd_last_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 hold_v_r, hold_v_nxt;

  // payload
  mt_pkg::word_t        val_r, val_nxt;           // seeding recurrence value
  mt_pkg::word_t        cur_r, cur_nxt;           // table[i] during twist
  mt_pkg::word_t        out_w_r, out_w_nxt;
  logic                 out_l_r, out_l_nxt;
  mt_pkg::word_t        hold_w_r, hold_w_nxt;
  logic                 hold_l_r, hold_l_nxt;

  // RAM ports
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  mt_pkg::word_t        wr_data;
  logic [AW-1:0]        rd_a_addr;
  mt_pkg::word_t        rd_a_data;
  logic [AW-1:0]        rd_b_addr;
  mt_pkg::word_t        rd_b_data;

  // helpers
  logic                 in_beat;
  logic                 take;
  logic                 out_free;
  logic [1:0]           occ;
  logic                 can_issue;
  logic                 issue;
  mt_pkg::count_t       req_cnt;
  logic [AW-1:0]        tw_i;
  logic [AW-1:0]        tw_next_a;
  logic [AW-1:0]        tw_far_a;
  mt_pkg::word_t        tw_y;
  mt_pkg::word_t        tw_new;
  mt_pkg::word_t        arr_w;
  mt_pkg::word_t        seed_mix;

  mt_ram #(
    .WIDTH (mt_pkg::WORD_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign in_beat         = in_valid && !in_stall;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_v_r;
  assign out_random_word = out_w_r;
  assign out_last_word   = out_l_r;

  assign take     = out_v_r && !out_stall;
  assign out_free = !out_v_r || take;
  // a read may go out only when a buffer slot is sure to be free on arrival
  assign occ       = 2'(rd_pend_r) + 2'(out_v_r) + 2'(hold_v_r);
  assign can_issue = (occ <= 2'd1) || ((occ == 2'd2) && take);

  assign req_cnt = (in_word_count > mt_pkg::COUNT_W'(mt_pkg::MAX_WORDS)) ?
                   mt_pkg::COUNT_W'(mt_pkg::MAX_WORDS) : in_word_count;

  // twist addressing for the entry being issued
  assign tw_i      = tw_cnt_r[AW-1:0];
  assign tw_next_a = (tw_i == AW'(TABLE_DEPTH - 1)) ? '0 : tw_i + AW'(1);
  assign tw_far_a  = (tw_i < AW'(FAR_LIM)) ? tw_i + AW'(mt_pkg::SHIFT_DIST)
                                           : tw_i - AW'(FAR_LIM);

  // twist datapath: cur_r is table[i], port A gives table[i+1], port B the far entry
  assign tw_y   = (cur_r & mt_pkg::UPPER_MASK) | (rd_a_data & mt_pkg::LOWER_MASK);
  assign tw_new = rd_b_data ^ (tw_y >> 1) ^ (tw_y[0] ? mt_pkg::TWIST_MAT : '0);

  assign arr_w    = mt_pkg::temper(rd_a_data);
  assign seed_mix = val_r ^ (val_r >> 30);

  assign issue = (state_r == ST_GEN) && !need_tw_r && can_issue;

  always_comb begin
    state_nxt   = state_r;
    seed_nxt    = seed_r;
    ready_nxt   = ready_r;
    need_tw_nxt = need_tw_r;
    idx_nxt     = idx_r;
    rem_nxt     = rem_r;
    fcnt_nxt    = fcnt_r;
    tw_cnt_nxt  = tw_cnt_r;
    tw_v_nxt    = 1'b0;
    tw_wa_nxt   = tw_wa_r;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;
    val_nxt     = val_r;
    cur_nxt     = cur_r;
    wr_en       = 1'b0;
    wr_addr     = fcnt_r;
    wr_data     = val_r;
    rd_a_addr   = idx_r;
    rd_b_addr   = tw_far_a;

    case (state_r)
      ST_IDLE: begin
        if (in_beat && (in_word_count != '0)) begin
          rem_nxt = req_cnt;
          if (ready_r) begin
            state_nxt = ST_GEN;
          end else begin
            state_nxt = ST_FILL;
            fcnt_nxt  = '0;
            val_nxt   = seed_r;
          end
        end
      end
      ST_FILL: begin
        // write one seeded entry per cycle and advance the recurrence
        wr_en    = 1'b1;
        fcnt_nxt = fcnt_r + AW'(1);
        val_nxt  = mt_pkg::WORD_W'(seed_mix * mt_pkg::SEED_MULT) +
                   mt_pkg::WORD_W'(fcnt_r) + mt_pkg::WORD_W'(1);
        if (fcnt_r == AW'(TABLE_DEPTH - 1)) begin
          ready_nxt   = 1'b1;
          need_tw_nxt = 1'b1;
          idx_nxt     = '0;
          state_nxt   = ST_GEN;
        end
      end
      ST_TWPRE: begin
        // prime cur_r with table[0]
        rd_a_addr  = '0;
        tw_cnt_nxt = '0;
        state_nxt  = ST_TWIST;
      end
      ST_TWIST: begin
        cur_nxt = rd_a_data;
        if (tw_cnt_r != CW'(TABLE_DEPTH)) begin
          rd_a_addr  = tw_next_a;
          tw_cnt_nxt = tw_cnt_r + CW'(1);
          tw_v_nxt   = 1'b1;
          tw_wa_nxt  = tw_i;
        end
        if (tw_v_r) begin
          wr_en   = 1'b1;
          wr_addr = tw_wa_r;
          wr_data = tw_new;
          if (tw_wa_r == AW'(TABLE_DEPTH - 1)) begin
            need_tw_nxt = 1'b0;
            state_nxt   = ST_GEN;
          end
        end
      end
      ST_GEN: begin
        if (need_tw_r) begin
          state_nxt = ST_TWPRE;
        end else if (issue) begin
          rd_pend_nxt = 1'b1;
          rd_last_nxt = (rem_r == mt_pkg::COUNT_W'(1));
          rem_nxt     = rem_r - mt_pkg::COUNT_W'(1);
          if (idx_r == AW'(TABLE_DEPTH - 1)) begin
            idx_nxt     = '0;
            need_tw_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
          if (rem_r == mt_pkg::COUNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // seed write: restart from an unseeded table
    if (cfg_valid && cfg_ready) begin
      seed_nxt    = cfg_seed_value;
      ready_nxt   = 1'b0;
      idx_nxt     = '0;
      need_tw_nxt = 1'b1;
    end
  end

  // output register with one holding stage behind it
  always_comb begin
    out_v_nxt  = out_v_r;
    out_w_nxt  = out_w_r;
    out_l_nxt  = out_l_r;
    hold_v_nxt = hold_v_r;
    hold_w_nxt = hold_w_r;
    hold_l_nxt = hold_l_r;
    if (hold_v_r) begin
      if (out_free) begin
        out_v_nxt  = 1'b1;
        out_w_nxt  = hold_w_r;
        out_l_nxt  = hold_l_r;
        hold_v_nxt = rd_pend_r;
        hold_w_nxt = arr_w;
        hold_l_nxt = rd_last_r;
      end
    end else if (rd_pend_r) begin
      if (out_free) begin
        out_v_nxt = 1'b1;
        out_w_nxt = arr_w;
        out_l_nxt = rd_last_r;
      end else begin
        hold_v_nxt = 1'b1;
        hold_w_nxt = arr_w;
        hold_l_nxt = rd_last_r;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      seed_r    <= mt_pkg::SEED_DEFAULT;
      ready_r   <= 1'b0;
      need_tw_r <= 1'b1;
      idx_r     <= '0;
      rem_r     <= '0;
      fcnt_r    <= '0;
      tw_cnt_r  <= '0;
      tw_v_r    <= 1'b0;
      tw_wa_r   <= '0;
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
      out_v_r   <= 1'b0;
      hold_v_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seed_r    <= seed_nxt;
      ready_r   <= ready_nxt;
      need_tw_r <= need_tw_nxt;
      idx_r     <= idx_nxt;
      rem_r     <= rem_nxt;
      fcnt_r    <= fcnt_nxt;
      tw_cnt_r  <= tw_cnt_nxt;
      tw_v_r    <= tw_v_nxt;
      tw_wa_r   <= tw_wa_nxt;
      rd_pend_r <= rd_pend_nxt;
      rd_last_r <= rd_last_nxt;
      out_v_r   <= out_v_nxt;
      hold_v_r  <= hold_v_nxt;
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    cur_r    <= cur_nxt;
    out_w_r  <= out_w_nxt;
    out_l_r  <= out_l_nxt;
    hold_w_r <= hold_w_nxt;
    hold_l_r <= hold_l_nxt;
  end

endmodule
